FILE: rtl/core/tta_pkg.sv
// Package: character codes and the fraction digit table for the temperature text formatter.
package tta_pkg;

	localparam int unsigned READING_W = 12;
	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned MAX_CHARS = 11;
	localparam int unsigned CNT_W     = 4;
	localparam int unsigned TEXT_W    = MAX_CHARS * CHAR_W;

	localparam logic [CHAR_W-1:0] CHR_PLUS   = 8'h2B;
	localparam logic [CHAR_W-1:0] CHR_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CHR_DOT    = 8'h2E;
	localparam logic [CHAR_W-1:0] CHR_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CHR_DEGREE = 8'hDF;
	localparam logic [CHAR_W-1:0] CHR_C      = 8'h43;
	localparam logic [CHAR_W-1:0] CHR_FILL   = 8'h00;

	// Four BCD digits of nib * 0.0625, most significant digit on top.
	function automatic logic [15:0] frac_bcd(input logic [3:0] nib);
		logic [15:0] d;
		unique case (nib)
			4'd0:  d = 16'h0000;
			4'd1:  d = 16'h0625;
			4'd2:  d = 16'h1250;
			4'd3:  d = 16'h1875;
			4'd4:  d = 16'h2500;
			4'd5:  d = 16'h3125;
			4'd6:  d = 16'h3750;
			4'd7:  d = 16'h4375;
			4'd8:  d = 16'h5000;
			4'd9:  d = 16'h5625;
			4'd10: d = 16'h6250;
			4'd11: d = 16'h6875;
			4'd12: d = 16'h7500;
			4'd13: d = 16'h8125;
			4'd14: d = 16'h8750;
			4'd15: d = 16'h9375;
			default: d = 16'h0000;
		endcase
		return d;
	endfunction

	// ASCII code of one decimal digit.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
		return CHR_ZERO | {4'h0, d};
	endfunction

endpackage

FILE: rtl/core/temperature_to_ascii_formatter.sv
// Top level: formats a signed 1/16-degree reading as decimal ASCII text, one byte per transaction.
//
//  channel    | handshake                    | payload            | per transaction
//  -----------+------------------------------+--------------------+------------------------
//  reading    | reading_valid / reading_ready | raw_reading[11:0]  | one sensor reading
//  char       | char_valid / char_ready       | character[7:0],last| one text byte
//
// Flow: a reading passes through the input register, then its whole text (9 to 11
// bytes) is formatted in one pass into a shift register that releases one byte per cycle
// while char_ready is high, so the char port and the text length set the reading rate.
// The next reading is taken into the input register while the current text drains, and
// is loaded in the cycle its predecessor's last byte leaves, so texts follow gap-free.
// Reset clears the input valid flag and the byte count; a stalled char port holds the
// current byte and, once the input register is full, drops reading_ready.
module temperature_to_ascii_formatter
	import tta_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        reading_valid,
	output logic                        reading_ready,
	input  logic signed [READING_W-1:0] raw_reading,
	output logic                        char_valid,
	input  logic                        char_ready,
	output logic        [CHAR_W-1:0]    character,
	output logic                        last
);

	// Input register stage.
	logic signed [READING_W-1:0] raw_s1;
	logic                        valid_s1;

	// Text shift register: current byte sits in the top byte.
	logic [TEXT_W-1:0] text_q;
	logic [CNT_W-1:0]  cnt_q;

	// Formatting logic.
	logic                 neg;
	logic [READING_W-1:0] mag;
	logic [7:0]           whole;
	logic                 hund;
	logic [6:0]           rem;
	logic [14:0]          tens_prod;
	logic [3:0]           tens;
	logic [6:0]           units_full;
	logic [3:0]           units;
	logic [15:0]          frac;
	logic [CHAR_W-1:0]    sign_ch;
	logic [7*CHAR_W-1:0]  tail;
	logic [TEXT_W-1:0]    text_d;
	logic [CNT_W-1:0]     cnt_d;

	logic out_xfer;
	logic load;

	always_comb begin
		neg   = raw_s1[READING_W-1];
		// Magnitude of -2048 is 2048, which still fits 12 bits unsigned.
		mag   = neg ? (READING_W'(0) - READING_W'(raw_s1)) : READING_W'(raw_s1);
		whole = mag[READING_W-1:4];
		hund  = (whole >= 8'd100);
		rem   = 7'(whole - (hund ? 8'd100 : 8'd0));
		// Divide by ten with a reciprocal; exact for values below 100.
		tens_prod  = 15'(rem) * 15'd205;
		tens       = tens_prod[14:11];
		units_full = rem - {tens, 3'b000} - {2'b00, tens, 1'b0};
		units      = units_full[3:0];
		frac       = frac_bcd(mag[3:0]);
		sign_ch    = neg ? CHR_MINUS : CHR_PLUS;
		tail = {CHR_DOT, digit_char(frac[15:12]), digit_char(frac[11:8]),
			digit_char(frac[7:4]), digit_char(frac[3:0]), CHR_DEGREE, CHR_C};
		// Leading zeros of the integer part drop; an interior zero stays.
		priority if (hund) begin
			text_d = {sign_ch, digit_char(4'd1), digit_char(tens), digit_char(units), tail};
			cnt_d  = CNT_W'(11);
		end else if (tens != 4'd0) begin
			text_d = {sign_ch, digit_char(tens), digit_char(units), tail, CHR_FILL};
			cnt_d  = CNT_W'(10);
		end else begin
			text_d = {sign_ch, digit_char(units), tail, CHR_FILL, CHR_FILL};
			cnt_d  = CNT_W'(9);
		end
	end

	assign char_valid = (cnt_q != '0);
	assign character  = text_q[TEXT_W-1 -: CHAR_W];
	assign last       = (cnt_q == CNT_W'(1));
	assign out_xfer   = char_valid && char_ready;

	// Load a new text when a reading waits and the buffer is empty or its final byte leaves now.
	assign load          = valid_s1 && (!char_valid || (last && char_ready));
	assign reading_ready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (reading_ready) begin
			valid_s1 <= reading_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (reading_ready && reading_valid) begin
			raw_s1 <= raw_reading;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= cnt_d;
		end else if (out_xfer) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Advance the text one byte per transaction.
	always_ff @(posedge clk) begin
		if (load) begin
			text_q <= text_d;
		end else if (out_xfer) begin
			text_q <= {text_q[TEXT_W-CHAR_W-1:0], CHR_FILL};
		end
	end

endmodule

FILE: rtl/core/tta_checker.sv
// Checker: port-level properties of the temperature text formatter, bound to the top level.
module tta_checker
	import tta_pkg::*;
(
	input logic                        clk,
	input logic                        arst_n,
	input logic                        reading_valid,
	input logic                        reading_ready,
	input logic signed [READING_W-1:0] raw_reading,
	input logic                        char_valid,
	input logic                        char_ready,
	input logic        [CHAR_W-1:0]    character,
	input logic                        last
);

	logic at_start_q;
	logic out_xfer;

	assign out_xfer = char_valid && char_ready;

	// Track whether the next byte opens a new text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
		end else if (out_xfer) begin
			at_start_q <= last;
		end
	end

	a_last_is_c: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && last |-> character == CHR_C)
		else $error("last byte is not 'C'");

	a_text_starts_with_sign: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && at_start_q |-> (character == CHR_PLUS || character == CHR_MINUS))
		else $error("text does not start with a sign");

	a_degree_then_c: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && character == CHR_DEGREE |=> char_valid && last && character == CHR_C)
		else $error("degree byte not followed by final 'C'");

	a_char_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_ready |=> char_valid && $stable(character) && $stable(last))
		else $error("stalled byte changed");

	// A waiting reading holds valid and its payload until it is taken.
	a_reading_hold: assert property (@(posedge clk) disable iff (!arst_n)
		reading_valid && !reading_ready |=> reading_valid && $stable(raw_reading))
		else $error("waiting reading changed");

endmodule

bind temperature_to_ascii_formatter tta_checker u_tta_checker (.*);

FILE: dv/temperature_to_ascii_formatter_test.sv
// Testbench for the temperature text formatter: directed and random readings, checked per byte.
module temperature_to_ascii_formatter_test;
	import tta_pkg::*;

	// One byte of formatted text as it should leave the char port.
	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              tail;
	} text_byte_t;

	localparam int CLK_PERIOD     = 20;
	localparam int RANDOM_ITEMS   = 160;
	localparam int PHASE_ITEMS    = 50;
	localparam int DIRECTED_ROWS  = 20;
	localparam int DRAIN_CYCLES   = 24;
	localparam int RUN_LIMIT      = 4000000;

	logic                        clk;
	logic                        arst_n;
	logic                        reading_valid;
	logic                        reading_ready;
	logic signed [READING_W-1:0] raw_reading;
	logic                        char_valid;
	logic                        char_ready;
	logic        [CHAR_W-1:0]    character;
	logic                        last;

	// Bytes still owed by the block, oldest first.
	text_byte_t expected_text_q[$];
	int         mismatch_count = 0;

	// Idle rates in percent: how often the reading side holds off a cycle and
	// how often the char side drops ready.
	int sender_idle_pct   = 0;
	int receiver_stall_pct = 0;

	// Directed table. An empty text means the row is checked against the
	// formatter model below; otherwise the text is typed in and only the
	// degree byte and the closing 'C' are appended.
	logic signed [READING_W-1:0] directed_reading [DIRECTED_ROWS] = '{
		12'sd0,       // zero reading
		12'sd2047,    // largest positive
		-12'sd2048,   // most negative, magnitude 128
		-12'sd1,      // negative with zero integer part
		12'sd1600,    // interior zero in the tens place
		-12'sd1600,
		12'sd1,
		12'sd15,
		-12'sd15,
		12'sd16,
		12'sd160,
		-12'sd160,
		12'sd144,
		12'sd1615,
		12'sd1685,
		-12'sd1366,   // alternating bits, one phase
		12'sd1365,    // alternating bits, other phase
		-12'sd2047,
		12'sd1760,
		-12'sd8
	};
	string directed_text [DIRECTED_ROWS] = '{
		"+0.0000", "+127.9375", "-128.0000", "-0.0625", "+100.0000", "-100.0000",
		"", "", "", "", "", "", "", "", "", "", "", "", "", ""
	};

	temperature_to_ascii_formatter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.reading_valid (reading_valid),
		.reading_ready (reading_ready),
		.raw_reading   (raw_reading),
		.char_valid    (char_valid),
		.char_ready    (char_ready),
		.character     (character),
		.last          (last)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop: the slowest legal run is far shorter than this.
	initial begin
		#RUN_LIMIT;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic void push_text_byte(input logic [CHAR_W-1:0] code, input logic tail);
		text_byte_t b;
		b.code = code;
		b.tail = tail;
		expected_text_q.push_back(b);
	endfunction

	function automatic logic [CHAR_W-1:0] ascii_digit(input int unsigned d);
		return CHR_ZERO + CHAR_W'(d);
	endfunction

	// Format one reading the way the block should: sign, integer part without
	// leading zeros, point, four fraction digits, degree byte, 'C'.
	function automatic void format_reading(input logic signed [READING_W-1:0] r);
		logic                 negative;
		logic [READING_W-1:0] magnitude;
		int unsigned          whole;
		int unsigned          frac;
		int unsigned          hundreds;
		int unsigned          tens;
		negative  = r[READING_W-1];
		// Two's complement of -2048 is 12'h800, which still reads as 2048 unsigned.
		magnitude = negative ? (~r + 1'b1) : r;
		whole     = 32'(magnitude[READING_W-1:4]);
		frac      = 0;
		if (magnitude[3]) frac += 5000;
		if (magnitude[2]) frac += 2500;
		if (magnitude[1]) frac += 1250;
		if (magnitude[0]) frac += 625;
		hundreds = whole / 100;
		tens     = (whole / 10) % 10;
		push_text_byte(negative ? CHR_MINUS : CHR_PLUS, 1'b0);
		if (hundreds != 0)
			push_text_byte(ascii_digit(hundreds), 1'b0);
		// Keep a zero tens digit when a hundreds digit stands before it.
		if (hundreds != 0 || tens != 0)
			push_text_byte(ascii_digit(tens), 1'b0);
		push_text_byte(ascii_digit(whole % 10), 1'b0);
		push_text_byte(CHR_DOT, 1'b0);
		push_text_byte(ascii_digit((frac / 1000) % 10), 1'b0);
		push_text_byte(ascii_digit((frac / 100) % 10), 1'b0);
		push_text_byte(ascii_digit((frac / 10) % 10), 1'b0);
		push_text_byte(ascii_digit(frac % 10), 1'b0);
		push_text_byte(CHR_DEGREE, 1'b0);
		push_text_byte(CHR_C, 1'b1);
	endfunction

	// Queue a typed-in text, closed by the degree byte and 'C'.
	function automatic void push_typed_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_text_byte(CHAR_W'(s[i]), 1'b0);
		push_text_byte(CHR_DEGREE, 1'b0);
		push_text_byte(CHR_C, 1'b1);
	endfunction

	// Offer one reading: idle at random first, then hold valid and the payload
	// until a rising edge sees ready. Expectations are queued at acceptance.
	// Called just after a rising edge (or at start), so the next falling edge
	// is where the inputs change.
	task automatic offer_reading(input logic signed [READING_W-1:0] r, input string text);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			reading_valid <= 1'b0;
			@(negedge clk);
		end
		reading_valid <= 1'b1;
		raw_reading   <= r;
		do
			@(posedge clk);
		while (!reading_ready);
		if (text.len() != 0)
			push_typed_text(text);
		else
			format_reading(r);
	endtask

	// Pick a random reading: full range, near zero, from 100 degrees upward, or a
	// whole number of degrees; the last two with a random sign.
	function automatic logic signed [READING_W-1:0] random_reading();
		logic signed [READING_W-1:0] r;
		case ($urandom_range(3))
			0: r = READING_W'($urandom_range(4095));
			1: r = READING_W'(int'($urandom_range(127)) - 64);
			2: begin
				r = READING_W'(1600 + $urandom_range(447));
				if ($urandom_range(1) == 1)
					r = -r;
			end
			default: begin
				r = READING_W'($urandom_range(127) << 4);
				if ($urandom_range(1) == 1)
					r = -r;
			end
		endcase
		return r;
	endfunction

	// Char side: drop ready at random at the configured rate; hold it low in reset.
	always @(negedge clk) begin
		if (!arst_n)
			char_ready <= 1'b0;
		else
			char_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Check every accepted byte against the oldest expectation, field by field.
	// Sampling right at the rising edge sees the values that the edge latches.
	always @(posedge clk) begin
		text_byte_t want;
		if (arst_n && char_valid && char_ready) begin
			if (expected_text_q.size() == 0) begin
				$display("%0t: unexpected byte: expected none, got character %h last %b",
					$time, character, last);
				mismatch_count++;
			end else begin
				want = expected_text_q.pop_front();
				if (character !== want.code) begin
					$display("%0t: character mismatch: expected %h, got %h",
						$time, want.code, character);
					mismatch_count++;
				end
				if (last !== want.tail) begin
					$display("%0t: last mismatch: expected %b, got %b",
						$time, want.tail, last);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		reading_valid = 1'b0;
		raw_reading   = '0;
		arst_n        = 1'b0;
		// Hold reset from the start, then release it away from the rising edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// First phase: sender idles rarely, receiver stalls often.
		sender_idle_pct    = 9;
		receiver_stall_pct = 74;
		for (int i = 0; i < DIRECTED_ROWS; i++)
			offer_reading(directed_reading[i], directed_text[i]);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// Swap the idle rates, then run the last stretch without idling.
			if (i == PHASE_ITEMS) begin
				sender_idle_pct    = 74;
				receiver_stall_pct = 9;
			end else if (i == 2 * PHASE_ITEMS) begin
				sender_idle_pct    = 0;
				receiver_stall_pct = 0;
			end
			offer_reading(random_reading(), "");
		end

		@(negedge clk);
		reading_valid <= 1'b0;

		// Drain the owed bytes; the hard stop covers a hung block.
		while (expected_text_q.size() != 0)
			@(posedge clk);
		// Let any stray bytes show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/tta_pkg.sv
rtl/core/temperature_to_ascii_formatter.sv
rtl/core/tta_checker.sv
dv/temperature_to_ascii_formatter_test.sv
